// ===== rtl/sinh_pkg.sv =====
// shared types and constants for the sinh series check
package sinh_pkg;

  localparam int XW        = 29;
  localparam int OW        = 36;
  localparam int TW        = 25;
  localparam int CW        = 6;
  localparam int AW        = 28;
  localparam int ACCW      = 56;
  localparam int DSW       = 15;
  localparam int EXP_TERMS = 48;
  localparam int MaxTermsDefault = 32;
  localparam logic [TW-1:0] TOL_RESET = TW'(16777);
  localparam logic [AW-1:0] X_LIMIT   = AW'(134217728);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP_MUL,
    ST_EXP_DIV,
    ST_EXP_ACC,
    ST_SINH,
    ST_SER_MUL1,
    ST_SER_MUL2,
    ST_SER_DIV,
    ST_SER_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            start;
    logic [ACCW-1:0] dividend;
    logic [DSW-1:0]  divisor;
  } div_req_t;

endpackage

// ===== rtl/sinh_div.sv =====
// bit-serial unsigned divider, one quotient bit per cycle
module sinh_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sinh_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic [sinh_pkg::ACCW-1:0] quot_o
);
  import sinh_pkg::*;

  localparam int SW = $clog2(ACCW + 1);

  logic [ACCW-1:0] quot_q, quot_d;
  logic [DSW-1:0]  rem_q, rem_d;
  logic [DSW-1:0]  dvs_q, dvs_d;
  logic [SW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DSW:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[ACCW-1]};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = SW'(ACCW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = DSW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[ACCW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DSW-1:0];
        quot_d = {quot_q[ACCW-2:0], 1'b0};
      end
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = busy_q && (cnt_q == SW'(1));
  assign quot_o = quot_d;

endmodule

// ===== rtl/sinh_taylor_series_check.sv =====
// top level: sinh reference by exponential, taylor series to tolerance or MAX_TERMS
//
// usage: drive x_value_i and raise start while busy is low; the request is
// taken at that edge and busy rises the next cycle. configuration: the
// tolerance register is written through cfg_valid_i/cfg_ready_o with
// cfg_data_i; only write it while busy is low.
// sequence: each of the 47 exponential terms multiplies the term by x in
// two halves on the shared 28x28 multiplier, divides it serially by n and
// accumulates it; the ST_SINH state then forms sinh and x squared. each
// series term multiplies by x squared as four partial products, divides
// serially by 2k(2k+1), accumulates and compares with the tolerance, and
// ST_DONE stops or goes on. one request at a time; busy is high through
// the result cycle and the next request is taken at the earliest at the
// end of the cycle after the result.
// results appear on the *_o result ports for one cycle with done_o high; the
// receiver cannot stall, so the result must be taken in that cycle.
// reset clears the sequencer and restores tolerance to about 0.001.
module sinh_taylor_series_check #(
  parameter int MAX_TERMS = sinh_pkg::MaxTermsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [sinh_pkg::XW-1:0] x_value_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sinh_pkg::TW-1:0]        cfg_data_i,
  output logic                           done_o,
  output logic signed [sinh_pkg::OW-1:0] sinh_value_o,
  output logic signed [sinh_pkg::OW-1:0] series_value_o,
  output logic [sinh_pkg::OW-1:0]        abs_difference_o,
  output logic [sinh_pkg::CW-1:0]        terms_used_o,
  output logic                           not_converged_o
);
  import sinh_pkg::*;

  localparam int KW = $clog2(MAX_TERMS + 2);
  localparam int NW = 6;
  localparam int PW = 2 * ACCW;

  state_e state_q, state_d;
  logic [TW-1:0]   tol_q;
  logic            neg_q, neg_d;
  logic [AW-1:0]   a_q, a_d;
  logic [ACCW-1:0] t_q, t_d;
  logic [ACCW+1:0] sp_q, sp_d;
  logic signed [ACCW+1:0] sm_q, sm_d;
  logic [NW-1:0]   n_q, n_d;
  logic [KW-1:0]   k_q, k_d;
  logic [DSW-1:0]  kdiv_q, kdiv_d;
  logic signed [OW-1:0] sinh_q, sinh_d, ser_q, ser_d;
  logic [OW-1:0]   diff_q, diff_d;
  logic [ACCW-1:0] smag_q, smag_d;
  logic [55:0]     x2_q, x2_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic            half_q, half_d;
  logic            conv_q, conv_d;

  // shared multiplier: 28 bit factor times 28 bit slice of the other
  logic [27:0] mul_a;
  logic [27:0] mul_b;
  logic [55:0] mul_p;
  assign mul_p = 56'(mul_a) * 56'(mul_b);

  div_req_t        dreq;
  logic            ddone;
  logic [ACCW-1:0] dquot;

  sinh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quot_o (dquot)
  );

  logic signed [XW-1:0] xs;
  logic [ACCW+1:0]      ep_l, em_l;
  logic [OW-1:0]        mag;
  logic signed [OW:0]   dif;
  logic [OW-1:0]        adif;

  always_comb begin
    xs = x_value_i;
    if (xs > $signed({1'b0, X_LIMIT})) xs = $signed({1'b0, X_LIMIT});
    if (xs < -$signed({1'b0, X_LIMIT})) xs = -$signed({1'b0, X_LIMIT});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start) state_d = ST_EXP_MUL;
      ST_EXP_MUL:  if (half_q) state_d = ST_EXP_DIV;
      ST_EXP_DIV:  if (ddone) state_d = ST_EXP_ACC;
      ST_EXP_ACC:  state_d = (n_q == NW'(EXP_TERMS - 1)) ? ST_SINH : ST_EXP_MUL;
      ST_SINH:     state_d = ST_SER_MUL1;
      ST_SER_MUL1: if (half_q) state_d = ST_SER_MUL2;
      ST_SER_MUL2: if (half_q) state_d = ST_SER_DIV;
      ST_SER_DIV:  if (ddone) state_d = ST_SER_ACC;
      ST_SER_ACC:  state_d = ST_DONE;
      ST_DONE:     state_d = (conv_q || k_q == KW'(MAX_TERMS)) ? ST_IDLE : ST_SER_MUL1;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    neg_d = neg_q; a_d = a_q; t_d = t_q; sp_d = sp_q; sm_d = sm_q; n_d = n_q;
    k_d = k_q; sinh_d = sinh_q; ser_d = ser_q; diff_d = diff_q; smag_d = smag_q;
    x2_d = x2_q; prod_d = prod_q; half_d = half_q; conv_d = conv_q;
    kdiv_d = kdiv_q;
    dreq = '0;
    mul_a = a_q;
    mul_b = half_q ? t_q[55:28] : t_q[27:0];
    ep_l = '0; em_l = '0; mag = '0; dif = '0; adif = '0;
    unique case (state_q)
      ST_IDLE: if (start) begin
        neg_d = xs[XW-1];
        a_d   = xs[XW-1] ? AW'(-xs) : AW'(xs);
        t_d   = ACCW'(1) << 40;
        sp_d  = (ACCW+2)'(1) << 40;
        sm_d  = (ACCW+2)'(1) << 40;
        n_d   = NW'(1);
        half_d = 1'b0;
      end
      ST_EXP_MUL: begin
        if (!half_q) prod_d = PW'(mul_p);
        else prod_d = prod_q + (PW'(mul_p) << 28);
        half_d = ~half_q;
        if (half_q) begin
          dreq.start    = 1'b1;
          dreq.dividend = ACCW'((prod_q + (PW'(mul_p) << 28)) >> 24);
          dreq.divisor  = DSW'(n_q);
        end
      end
      ST_EXP_DIV: if (ddone) t_d = dquot;
      ST_EXP_ACC: begin
        sp_d = sp_q + (ACCW+2)'(t_q);
        sm_d = n_q[0] ? sm_q - $signed((ACCW+2)'(t_q)) : sm_q + $signed((ACCW+2)'(t_q));
        n_d  = n_q + NW'(1);
      end
      ST_SINH: begin
        ep_l = sp_q >> 16;
        em_l = sm_q[ACCW+1] ? '0 : {16'd0, sm_q[ACCW+1:16]};
        mag  = OW'((ep_l - em_l) >> 1);
        sinh_d = neg_q ? -$signed(mag) : $signed(mag);
        mul_b = a_q;
        x2_d  = mul_p;
        t_d   = ACCW'(a_q);
        smag_d = ACCW'(a_q);
        k_d   = KW'(1);
        kdiv_d = DSW'(6);
        half_d = 1'b0;
      end
      ST_SER_MUL1: begin
        // t * x2 as four 28x28 partial products, low half of x2 first, shift 48 total
        mul_a = x2_q[27:0];
        if (!half_q) prod_d = PW'(mul_p);
        else prod_d = prod_q + (PW'(mul_p) << 28);
        half_d = ~half_q;
      end
      ST_SER_MUL2: begin
        mul_a = x2_q[55:28];
        if (!half_q) prod_d = prod_q + (PW'(mul_p) << 28);
        else prod_d = prod_q + (PW'(mul_p) << 56);
        half_d = ~half_q;
        if (half_q) begin
          dreq.start    = 1'b1;
          dreq.dividend = ACCW'((prod_q + (PW'(mul_p) << 56)) >> 48);
          dreq.divisor  = kdiv_q;
        end
      end
      ST_SER_DIV: if (ddone) t_d = dquot;
      ST_SER_ACC: begin
        smag_d = smag_q + t_q;
        ser_d  = neg_q ? -$signed(OW'(smag_q + t_q)) : $signed(OW'(smag_q + t_q));
        dif    = (OW+1)'(sinh_q) - (OW+1)'(ser_d);
        adif   = dif[OW] ? OW'(-dif) : OW'(dif);
        diff_d = adif;
        conv_d = adif < OW'(tol_q);
      end
      ST_DONE: if (!(conv_q || k_q == KW'(MAX_TERMS))) begin
        k_d = k_q + KW'(1);
        // (2k+2)(2k+3) = 2k(2k+1) + 8k + 6
        kdiv_d = kdiv_q + DSW'({k_q, 3'b000}) + DSW'(6);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tol_q   <= TOL_RESET;
      half_q  <= 1'b0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      half_q  <= half_d;
      conv_q  <= conv_d;
      if (cfg_valid_i && cfg_ready_o) tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; a_q <= a_d; t_q <= t_d; sp_q <= sp_d; sm_q <= sm_d;
    n_q <= n_d; k_q <= k_d; sinh_q <= sinh_d; ser_q <= ser_d; diff_q <= diff_d;
    smag_q <= smag_d; x2_q <= x2_d; prod_q <= prod_d; kdiv_q <= kdiv_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o = (state_q == ST_DONE) && (conv_q || k_q == KW'(MAX_TERMS));
  assign sinh_value_o     = sinh_q;
  assign series_value_o   = ser_q;
  assign abs_difference_o = diff_q;
  assign terms_used_o     = CW'(k_q + KW'(1));
  assign not_converged_o  = ~conv_q;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> k_q <= KW'(MAX_TERMS) || state_q != ST_DONE) else $error("k past limit");
`endif

endmodule
